// ----- rtl/spt_pkg.sv -----
// Shared types, register map and lookup tables for the servo pulse train generator.
package spt_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_PERIOD = 2'd0,
		REG_OFFSET = 2'd1,
		REG_ALIGN  = 2'd2,
		REG_MARGIN = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_TICK     = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	localparam logic [15:0] PERIOD_RST = 16'd20000;
	localparam logic [11:0] OFFSET_RST = 12'd546;
	localparam logic [7:0]  ALIGN_RST  = 8'd40;
	localparam logic [7:0]  MARGIN_RST = 8'd10;
	localparam logic [11:0] HT_MAX     = 12'd4095;

	typedef struct packed {
		logic       command;
		logic [7:0] angle;
		logic       hold;
		logic       align;
	} req_t;

	typedef struct packed {
		logic       pin_level;
		logic       busy_res;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [15:0] period_us;
		logic [11:0] offset_us;
		logic [7:0]  align_pulses;
		logic [7:0]  margin_pulses;
	} cfg_t;

	// floor(10.3 * angle) for every 8-bit angle
	typedef logic [255:0][11:0] ht_tab_t;
	// trunc(diff * 33 / 180) for every 8-bit angle difference
	typedef logic [255:0][5:0] cnt_tab_t;

	function automatic ht_tab_t mk_ht_tab();
		ht_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 12'((103 * i) / 10);
		end
		return t;
	endfunction

	function automatic cnt_tab_t mk_cnt_tab();
		cnt_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 6'((33 * i) / 180);
		end
		return t;
	endfunction

	localparam ht_tab_t  HT_TAB  = mk_ht_tab();
	localparam cnt_tab_t CNT_TAB = mk_cnt_tab();

endpackage

// ----- rtl/servo_pulse_train_generator.sv -----
// Top level of the servo pulse train generator: request handling, pulse state, result register.
//
// Each request (a one-microsecond tick or a move command) is handled when it is accepted: the
// pulse state is updated and the result is loaded into the output register at that edge,
// so it appears on out_data in the following cycle. A new request is taken every cycle as long
// as the result register is empty or being drained; out_ready low stalls the input only when a
// result is already waiting. The high time uses a 256-entry angle table and a saturating add;
// a plain move's pulse count uses a 256-entry table on the angle difference plus the margin.
module servo_pulse_train_generator
	import spt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	logic [7:0]  last_angle_q;
	logic [11:0] high_time_q;
	logic [8:0]  pulses_left_q;
	logic        hold_active_q;
	logic [15:0] phase_q;
	logic        out_valid_q;
	res_t        out_q;

	logic        take;
	logic        busy;
	logic        level;
	logic        wrap;
	logic [7:0]  diff;
	logic [12:0] ht_sum;
	logic [11:0] ht_new;
	logic [8:0]  cnt_new;
	logic        busy_new;

	logic [7:0]  last_angle_d;
	logic [11:0] high_time_d;
	logic [8:0]  pulses_left_d;
	logic        hold_active_d;
	logic [15:0] phase_d;
	res_t        res_d;

	spt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign busy  = (pulses_left_q != 9'd0) || hold_active_q;
	assign level = busy && ({4'd0, high_time_q} > phase_q);
	// period zero behaves as one tick: the compare below is then always true
	assign wrap  = ({1'b0, phase_q} + 17'd1) >= {1'b0, cfg.period_us};

	assign diff   = (in_data.angle >= last_angle_q) ? in_data.angle - last_angle_q
	                                                : last_angle_q - in_data.angle;
	assign ht_sum = {1'b0, cfg.offset_us} + {1'b0, HT_TAB[in_data.angle]};
	assign ht_new = ht_sum[12] ? HT_MAX : ht_sum[11:0];

	always_comb begin
		if (in_data.hold) begin
			cnt_new = 9'd0;
		end else if (in_data.align) begin
			cnt_new = {1'b0, cfg.align_pulses};
		end else begin
			cnt_new = {3'd0, CNT_TAB[diff]} + {1'b0, cfg.margin_pulses};
		end
	end

	assign busy_new = in_data.hold || (cnt_new != 9'd0);

	always_comb begin
		last_angle_d  = last_angle_q;
		high_time_d   = high_time_q;
		pulses_left_d = pulses_left_q;
		hold_active_d = hold_active_q;
		phase_d       = phase_q;
		res_d.pin_level = level;
		res_d.busy_res  = busy;
		res_d.status    = ST_TICK;
		if (!in_data.command) begin
			if (busy) begin
				if (wrap) begin
					phase_d = '0;
					if (!hold_active_q && pulses_left_q != 9'd0) begin
						pulses_left_d = pulses_left_q - 9'd1;
					end
				end else begin
					phase_d = phase_q + 16'd1;
				end
			end else begin
				phase_d = '0;
			end
			res_d.busy_res = (pulses_left_d != 9'd0) || hold_active_q;
		end else if (busy) begin
			res_d.status = ST_REJECTED;
		end else begin
			high_time_d   = ht_new;
			phase_d       = '0;
			pulses_left_d = cnt_new;
			hold_active_d = in_data.hold;
			last_angle_d  = in_data.angle;
			res_d.pin_level = busy_new && (ht_new != 12'd0);
			res_d.busy_res  = busy_new;
			res_d.status    = ST_ACCEPTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q  <= '0;
			high_time_q   <= '0;
			pulses_left_q <= '0;
			hold_active_q <= 1'b0;
			phase_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				last_angle_q  <= last_angle_d;
				high_time_q   <= high_time_d;
				pulses_left_q <= pulses_left_d;
				hold_active_q <= hold_active_d;
				phase_q       <= phase_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res_d;
		end
	end

endmodule

// ----- rtl/spt_regs.sv -----
// APB-style configuration register file for the servo pulse train generator.
module spt_regs
	import spt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_us     <= PERIOD_RST;
			cfg_q.offset_us     <= OFFSET_RST;
			cfg_q.align_pulses  <= ALIGN_RST;
			cfg_q.margin_pulses <= MARGIN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PERIOD: cfg_q.period_us     <= pwdata[15:0];
				REG_OFFSET: cfg_q.offset_us     <= pwdata[11:0];
				REG_ALIGN:  cfg_q.align_pulses  <= pwdata[7:0];
				REG_MARGIN: cfg_q.margin_pulses <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PERIOD: prdata = DATA_W'(cfg_q.period_us);
			REG_OFFSET: prdata = DATA_W'(cfg_q.offset_us);
			REG_ALIGN:  prdata = DATA_W'(cfg_q.align_pulses);
			REG_MARGIN: prdata = DATA_W'(cfg_q.margin_pulses);
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- bench/spt_checker.sv -----
`timescale 1ns / 1ps
// Checker for the servo pulse train generator: follows requests and writes, predicts, compares.
module spt_checker
	import spt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  req_t              in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  res_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fail_count,
	output int                pending
);

	cfg_t        cfg;
	logic [7:0]  last_ang;
	logic [11:0] high_t;
	logic [8:0]  pulses;
	logic        hold_on;
	logic [15:0] phase;
	res_t        servo_out_q[$];

	function automatic logic servo_busy();
		return (pulses != 9'd0) || hold_on;
	endfunction

	function automatic res_t advance_servo(input req_t r);
		res_t        o;
		logic [16:0] per;
		int          ht;
		int          diff;
		o = '0;
		if (!r.command) begin
			if (servo_busy()) begin
				per = (cfg.period_us == 16'd0) ? 17'd1 : {1'b0, cfg.period_us};
				o.pin_level = (phase < high_t);
				if ({1'b0, phase} + 17'd1 >= per) begin
					phase = 16'd0;
					if (!hold_on && pulses != 9'd0)
						pulses = pulses - 9'd1;
				end else begin
					phase = phase + 16'd1;
				end
			end else begin
				o.pin_level = 1'b0;
				phase = 16'd0;
			end
			o.status = ST_TICK;
		end else if (servo_busy()) begin
			o.pin_level = (phase < high_t);
			o.status = ST_REJECTED;
		end else begin
			ht = int'(cfg.offset_us) + (103 * int'(r.angle)) / 10;
			if (ht > int'(HT_MAX))
				ht = int'(HT_MAX);
			high_t = 12'(ht);
			phase = 16'd0;
			if (r.hold) begin
				hold_on = 1'b1;
				pulses = 9'd0;
			end else if (r.align) begin
				pulses = {1'b0, cfg.align_pulses};
			end else begin
				diff = (r.angle >= last_ang) ? int'(r.angle) - int'(last_ang)
					: int'(last_ang) - int'(r.angle);
				pulses = 9'((diff * 33) / 180 + int'(cfg.margin_pulses));
			end
			last_ang = r.angle;
			o.pin_level = servo_busy() && (phase < high_t);
			o.status = ST_ACCEPTED;
		end
		o.busy_res = servo_busy();
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			cfg = '{PERIOD_RST, OFFSET_RST, ALIGN_RST, MARGIN_RST};
			last_ang = '0;
			high_t = '0;
			pulses = '0;
			hold_on = 1'b0;
			phase = '0;
			servo_out_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (servo_out_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result pin %0d busy %0d status %0d", $realtime,
							out_data.pin_level, out_data.busy_res, out_data.status);
				end else begin
					want = servo_out_q.pop_front();
					if (out_data.pin_level !== want.pin_level || out_data.busy_res !== want.busy_res
						|| out_data.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch expected pin %0d busy %0d status %0d, got pin %0d busy %0d status %0d",
								$realtime, want.pin_level, want.busy_res, want.status,
								out_data.pin_level, out_data.busy_res, out_data.status);
					end
				end
			end
			if (in_valid && in_ready)
				servo_out_q.push_back(advance_servo(in_data));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_PERIOD: cfg.period_us = pwdata[15:0];
					REG_OFFSET: cfg.offset_us = pwdata[11:0];
					REG_ALIGN:  cfg.align_pulses = pwdata[7:0];
					REG_MARGIN: cfg.margin_pulses = pwdata[7:0];
					default: ;
				endcase
			end
			pending = servo_out_q.size();
		end
	end

endmodule

// ----- bench/tb_servo_pulse_train_generator.sv -----
`timescale 1ns / 1ps
// Testbench top for the servo pulse train generator: clock, reset, stimulus and verdict.
module tb_servo_pulse_train_generator;
	import spt_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	req_t              in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	res_t              out_data;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	bit                bursts_on = 1'b1;
	bit                seen_busy = 1'b0;
	int                stall_left = 0;

	always #1 clk = ~clk;

	servo_pulse_train_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	spt_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			seen_busy <= out_data.busy_res;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input req_t r);
		if (bursts_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_cfg(input int per, input int off, input int aln, input int mrg);
		write_reg(REG_PERIOD, DATA_W'(per));
		write_reg(REG_OFFSET, DATA_W'(off));
		write_reg(REG_ALIGN, DATA_W'(aln));
		write_reg(REG_MARGIN, DATA_W'(mrg));
	endtask

	function automatic req_t mk_req(input bit cmd, input logic [7:0] ang, input bit hld,
		input bit aln);
		req_t r;
		r.command = cmd;
		r.angle = ang;
		r.hold = hld;
		r.align = aln;
		return r;
	endfunction

	// moves mostly while idle; narrow angles in pattern phases keep the high time short
	function automatic req_t pick_request(input bit pattern);
		req_t r;
		int   sel;
		r.command = seen_busy ? ($urandom_range(0, 24) == 0) : ($urandom_range(0, 2) == 0);
		r.angle = 8'($urandom);
		r.hold = 1'($urandom);
		r.align = 1'($urandom);
		if (r.command) begin
			r.hold = 1'b0;
			r.align = pattern ? 1'($urandom) : ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (pattern)
				r.angle = 8'($urandom_range(0, 3));
			else if (sel == 0)
				r.angle = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd180 : 8'd255);
			else if (sel == 1)
				r.angle = 8'($urandom_range(181, 255));
			else
				r.angle = 8'($urandom_range(0, 180));
		end
		return r;
	endfunction

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int   k;
		int   n;
		bit   pattern;
		req_t r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle tick, move, rejected moves
		send_req(mk_req(1'b0, 8'd255, 1'b1, 1'b1));
		send_req(mk_req(1'b1, 8'd0, 1'b0, 1'b0));
		send_req(mk_req(1'b0, 8'd0, 1'b0, 1'b0));
		send_req(mk_req(1'b1, 8'd180, 1'b1, 1'b0));
		send_req(mk_req(1'b1, 8'd255, 1'b0, 1'b1));
		quiesce();
		// zero period while busy, saturating offset, zero counts
		write_cfg(0, 4095, 0, 0);
		repeat (10) send_req(mk_req(1'b0, 8'd0, 1'b0, 1'b0));
		send_req(mk_req(1'b0, 8'd128, 1'b0, 1'b1));
		send_req(mk_req(1'b1, 8'd0, 1'b0, 1'b1));
		send_req(mk_req(1'b1, 8'd4, 1'b0, 1'b0));
		send_req(mk_req(1'b1, 8'd255, 1'b0, 1'b0));
		send_req(mk_req(1'b0, 8'd0, 1'b0, 1'b0));
		send_req(mk_req(1'b1, 8'd180, 1'b0, 1'b0));

		for (k = 0; k < 9; k++) begin
			quiesce();
			pattern = (k % 2 == 1) && (k > 1);
			if (k == 0)
				write_cfg(65535, 4095, 255, 255);
			else if (k == 1)
				write_cfg(2400, 0, 0, 0);
			else if (pattern)
				write_cfg($urandom_range(8, 24), $urandom_range(0, 6), $urandom_range(1, 4),
					$urandom_range(0, 3));
			else
				write_cfg($urandom_range(0, 4), $urandom_range(0, 600), $urandom_range(0, 30),
					$urandom_range(0, 8));
			bursts_on = (k % 3 != 2);
			n = (k < 2) ? 40 : 160;
			repeat (n) send_req(pick_request(pattern));
		end

		// last part: drain, then hold mode for the rest of the run
		quiesce();
		bursts_on = 1'b0;
		write_reg(REG_PERIOD, DATA_W'(0));
		while (seen_busy) begin
			send_req(mk_req(1'b0, 8'($urandom), 1'($urandom), 1'($urandom)));
			quiesce();
		end
		write_reg(REG_PERIOD, DATA_W'(6));
		write_reg(REG_OFFSET, DATA_W'(2));
		send_req(mk_req(1'b1, 8'd0, 1'b1, 1'b1));
		repeat (150) begin
			r = pick_request(1'b1);
			if (r.command)
				r.hold = 1'($urandom);
			send_req(r);
		end
		in_valid <= 1'b0;

		for (int c = 0; c < 100000 && pending != 0; c++) @(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
